// File: rtl/rmst_pkg.sv
// ----------------------------------------------------------------------------
// rmst_pkg
// Shared sizes, value constants and command codes for the range-minimum
// segment tree.
// ----------------------------------------------------------------------------
package rmst_pkg;

  localparam int LEAVES     = 1024;
  localparam int NODES      = 2 * LEAVES;
  localparam int VALUE_BITS = 48;
  localparam int POS_BITS   = 11;
  localparam int NODE_BITS  = $clog2(NODES);

  localparam logic signed [VALUE_BITS-1:0] EMPTY_VALUE = {1'b0, {(VALUE_BITS-1){1'b1}}};

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } command_t;

  function automatic logic signed [VALUE_BITS-1:0] min_value(
    input logic signed [VALUE_BITS-1:0] a,
    input logic signed [VALUE_BITS-1:0] b
  );
    min_value = (a < b) ? a : b;
  endfunction

endpackage

// File: rtl/range_min_segment_tree.sv
// ----------------------------------------------------------------------------
// range_min_segment_tree
// Range-minimum segment tree over positions 1..active_size, clamped to 1..1024;
// node minima held in one single-port synchronous RAM.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Beat contents
// cfg       in         cfg_we              cfg_wdata -> active_size
// in        in         in_valid/in_stall   command, position, key_value,
//                                          range_low, range_high
// out       out        out_valid/out_stall minimum_value, range_error
//
// Write: walks down level by level and writes the leaf, then per level going
// up reads the sibling and writes the parent on the single RAM port.
// Query: steps through the visited nodes one at a time.
// Clear and reset: a sweep over all 2048 RAM entries, one per cycle; in_stall
// stays high for the whole sweep.
// A finished query result waits in the output register while the next beat
// is taken; a second result waits internally until that register drains.
// ----------------------------------------------------------------------------
module range_min_segment_tree import rmst_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [POS_BITS-1:0]          cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   command,
  input  logic [POS_BITS-1:0]          position,
  input  logic signed [VALUE_BITS-1:0] key_value,
  input  logic [POS_BITS-1:0]          range_low,
  input  logic [POS_BITS-1:0]          range_high,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [VALUE_BITS-1:0] minimum_value,
  output logic                         range_error
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_DOWN,
    ST_WR_RD,
    ST_WR_UP,
    ST_Q_STEP,
    ST_Q_LAST,
    ST_DONE
  } state_t;

  state_t state;

  logic [POS_BITS-1:0]          active_size;
  logic [NODE_BITS-1:0]         clr_addr;

  logic [NODE_BITS-1:0]         k;
  logic [POS_BITS-1:0]          l;
  logic [POS_BITS-1:0]          r;
  logic [POS_BITS-1:0]          lo;
  logic [POS_BITS-1:0]          hi;
  logic signed [VALUE_BITS-1:0] key;
  logic signed [VALUE_BITS-1:0] acc;
  logic                         err;
  logic                         rd_pend;

  logic                         pend_valid;
  logic [NODE_BITS-1:0]         pend_k;
  logic [POS_BITS-1:0]          pend_l;
  logic [POS_BITS-1:0]          pend_r;
  logic [POS_BITS-1:0]          pend_lo;
  logic [POS_BITS-1:0]          pend_hi;

  logic signed [VALUE_BITS-1:0] node_mem [NODES];
  logic [NODE_BITS-1:0]         mem_addr;
  logic                         mem_we;
  logic signed [VALUE_BITS-1:0] mem_wdata;
  logic signed [VALUE_BITS-1:0] mem_rdata;

  logic [POS_BITS-1:0]          size_n;
  logic [POS_BITS-1:0]          mid;
  logic [POS_BITS-1:0]          mid_inc;
  logic [NODE_BITS-1:0]         k_left;
  logic [NODE_BITS-1:0]         k_right;
  logic [NODE_BITS-1:0]         k_sib;
  logic [NODE_BITS-1:0]         k_par;
  logic signed [VALUE_BITS-1:0] rd_min;
  logic signed [VALUE_BITS-1:0] acc_merged;
  logic                         q_full;
  logic                         q_read;
  logic                         q_bad;
  logic                         out_free;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    if (active_size == '0) begin
      size_n = POS_BITS'(1);
    end else if (active_size > POS_BITS'(LEAVES)) begin
      size_n = POS_BITS'(LEAVES);
    end else begin
      size_n = active_size;
    end
  end

  assign mid        = POS_BITS'(({1'b0, l} + {1'b0, r}) >> 1);
  assign mid_inc    = mid + POS_BITS'(1);
  assign k_left     = {k[NODE_BITS-2:0], 1'b0};
  assign k_right    = {k[NODE_BITS-2:0], 1'b1};
  assign k_sib      = {k[NODE_BITS-1:1], ~k[0]};
  assign k_par      = {1'b0, k[NODE_BITS-1:1]};
  assign rd_min     = min_value(acc, mem_rdata);
  assign acc_merged = rd_pend ? rd_min : acc;
  assign q_full     = (lo == l) && (hi == r);
  assign q_bad      = (range_low == '0) || (range_high > size_n) || (range_low > range_high);

  // RAM port steering
  always_comb begin
    mem_addr  = k;
    mem_we    = 1'b0;
    mem_wdata = EMPTY_VALUE;
    q_read    = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_addr = clr_addr;
        mem_we   = 1'b1;
      end
      ST_WR_DOWN: begin
        if (l == r) begin
          mem_we    = 1'b1;
          mem_wdata = key;
        end
      end
      ST_WR_RD: begin
        mem_addr = k_sib;
      end
      ST_WR_UP: begin
        mem_addr  = k_par;
        mem_we    = 1'b1;
        mem_wdata = rd_min;
      end
      ST_Q_STEP: begin
        if (q_full) begin
          q_read = 1'b1;
        end else if (hi <= mid || lo > mid) begin
          q_read = 1'b0;
        end else if (hi == r) begin
          mem_addr = k_right;
          q_read   = 1'b1;
        end else if (lo == l) begin
          mem_addr = k_left;
          q_read   = 1'b1;
        end
      end
      default: begin
        mem_addr = k;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[mem_addr] <= mem_wdata;
    end
    mem_rdata <= node_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      active_size <= POS_BITS'(LEAVES);
      out_valid   <= 1'b0;
      rd_pend     <= 1'b0;
      pend_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        active_size <= cfg_wdata;
      end
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      rd_pend <= q_read;

      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + NODE_BITS'(1);
          if (clr_addr == NODE_BITS'(NODES - 1)) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (in_valid) begin
            case (command)
              CMD_WRITE: begin
                if (position != '0 && position <= size_n) begin
                  k     <= NODE_BITS'(1);
                  l     <= POS_BITS'(1);
                  r     <= size_n;
                  lo    <= position;
                  key   <= key_value;
                  state <= ST_WR_DOWN;
                end
              end
              CMD_QUERY: begin
                acc <= EMPTY_VALUE;
                if (q_bad) begin
                  err   <= 1'b1;
                  state <= ST_DONE;
                end else begin
                  err        <= 1'b0;
                  k          <= NODE_BITS'(1);
                  l          <= POS_BITS'(1);
                  r          <= size_n;
                  lo         <= range_low;
                  hi         <= range_high;
                  pend_valid <= 1'b0;
                  state      <= ST_Q_STEP;
                end
              end
              CMD_CLEAR: begin
                clr_addr <= '0;
                state    <= ST_CLEAR;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end

        ST_WR_DOWN: begin
          if (l == r) begin
            acc   <= key;
            state <= ST_WR_RD;
          end else if (lo <= mid) begin
            k <= k_left;
            r <= mid;
          end else begin
            k <= k_right;
            l <= mid_inc;
          end
        end

        ST_WR_RD: begin
          if (k == NODE_BITS'(1)) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_WR_UP;
          end
        end

        ST_WR_UP: begin
          acc   <= rd_min;
          k     <= k_par;
          state <= ST_WR_RD;
        end

        ST_Q_STEP: begin
          acc <= acc_merged;
          if (q_full) begin
            if (pend_valid) begin
              k          <= pend_k;
              l          <= pend_l;
              r          <= pend_r;
              lo         <= pend_lo;
              hi         <= pend_hi;
              pend_valid <= 1'b0;
            end else begin
              state <= ST_Q_LAST;
            end
          end else if (hi <= mid) begin
            k <= k_left;
            r <= mid;
          end else if (lo > mid) begin
            k <= k_right;
            l <= mid_inc;
          end else if (hi == r) begin
            k  <= k_left;
            r  <= mid;
            hi <= mid;
          end else if (lo == l) begin
            k  <= k_right;
            l  <= mid_inc;
            lo <= mid_inc;
          end else begin
            // split point: hold the right branch, follow the left one
            pend_k     <= k_right;
            pend_l     <= mid_inc;
            pend_r     <= r;
            pend_lo    <= mid_inc;
            pend_hi    <= hi;
            pend_valid <= 1'b1;
            k          <= k_left;
            r          <= mid;
            hi         <= mid;
          end
        end

        ST_Q_LAST: begin
          acc   <= acc_merged;
          state <= ST_DONE;
        end

        ST_DONE: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            minimum_value <= acc;
            range_error   <= err;
            state         <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/rmst_checker.sv
// ----------------------------------------------------------------------------
// rmst_checker
// Port-level checks on the range-minimum segment tree, bound to the top level.
// ----------------------------------------------------------------------------
module rmst_checker import rmst_pkg::*; (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [1:0]                   command,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [VALUE_BITS-1:0] minimum_value,
  input logic                         range_error
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(minimum_value) && $stable(range_error))
    else $error("stalled result beat changed");

  a_err_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> minimum_value == EMPTY_VALUE)
    else $error("rejected range without empty value");

  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && command != CMD_NOP && command != CMD_WRITE |=> in_stall)
    else $error("query or clear beat did not occupy the block");

  a_reset_sweep: assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("input taken or result shown right after reset");

endmodule

bind range_min_segment_tree rmst_checker u_rmst_checker (.*);
